@@ hdl/cwra_pkg.sv @@
// Package for the centered window row average block.
// Holds widths, the job record passed from front to back, and state enums.
package cwra_pkg;

    localparam int unsigned MaxStep    = 64;
    localparam int unsigned MaxTexels  = 4096;
    localparam int unsigned MaxFrames  = 65536;

    localparam int unsigned StepW   = 7;   // window_step register width
    localparam int unsigned TpfW    = 13;  // texels_per_frame register width
    localparam int unsigned TexW    = 12;  // texel position
    localparam int unsigned FrameW  = 16;  // frame counter
    localparam int unsigned SlotW   = 6;   // ring slot
    localparam int unsigned SumW    = 14;  // running window sum
    localparam int unsigned PixW    = 8;   // texel byte
    localparam int unsigned HistAW  = SlotW + TexW;
    localparam int unsigned CfgIdxW = 1;
    localparam int unsigned CfgW    = 13;
    localparam int unsigned OutW    = 40;  // avg + frame + texel, byte padded

    localparam logic [CfgIdxW-1:0] RegStep = 1'b0;
    localparam logic [CfgIdxW-1:0] RegTpf  = 1'b1;

    // One accepted texel after the sum update
    typedef struct packed {
        logic [TexW-1:0]   k;
        logic [FrameW-1:0] f;
        logic [SlotW-1:0]  slot;
        logic [SumW-1:0]   sum;
        logic              fin;
    } t_job;

    // Back-side read request into the frame history
    typedef struct packed {
        logic              en;
        logic [HistAW-1:0] addr;
    } t_hist_rd;

    typedef enum logic {F_IDLE, F_CALC} t_front_state;

    typedef enum logic [2:0] {B_IDLE, B_CHECK, B_WAIT, B_DIV, B_OUT} t_back_state;

endpackage

@@ hdl/cwra_front.sv @@
// Front part: accepts texels, keeps counters, updates history and sums.
// Depends on cwra_pkg; owns the frame history and column sum memories.
module cwra_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [cwra_pkg::PixW-1:0]       i_texel,
    input  logic                            i_fin,
    input  logic                            i_cfg_we,
    input  logic [cwra_pkg::StepW-1:0]      i_step,
    input  logic [cwra_pkg::TpfW-1:0]       i_tpf,
    input  logic                            i_q_full,
    input  logic                            i_q_empty,
    input  logic                            i_back_idle,
    output logic                            o_push,
    output cwra_pkg::t_job                  o_job,
    input  cwra_pkg::t_hist_rd              i_bk_rd,
    output logic [cwra_pkg::PixW-1:0]       o_bk_data
);
    import cwra_pkg::*;

    logic [PixW-1:0] hist_mem [MaxStep*MaxTexels];
    logic [SumW-1:0] sum_mem  [MaxTexels];

    t_front_state r_state, n_state;
    logic [TexW-1:0]   r_k;
    logic [FrameW-1:0] r_f;
    logic [SlotW-1:0]  r_slot;
    logic              r_drain;
    logic [TexW-1:0]   r_jk;
    logic [FrameW-1:0] r_jf;
    logic [SlotW-1:0]  r_jslot;
    logic [PixW-1:0]   r_v;
    logic              r_jfin;
    logic [PixW-1:0]   r_hist_rd;
    logic [SumW-1:0]   r_sum_rd;
    logic [PixW-1:0]   r_bk_data;

    logic              accept;
    logic [TexW-1:0]   k_use;
    logic [SumW-1:0]   new_sum;
    logic              wrap;

    assign accept = i_valid && o_ready;
    assign k_use  = ({1'b0, r_k} >= i_tpf) ? '0 : r_k;
    assign wrap   = ({1'b0, r_jk} + 13'd1) >= i_tpf;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (accept) n_state = F_CALC;
            F_CALC:  n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ready = (r_state == F_IDLE) && !i_q_full && !r_drain;
        o_push  = (r_state == F_CALC);
    end

    // Sum update: a new run starts from zero, a full window drops its oldest frame
    always_comb begin
        logic [SumW-1:0] base;
        base = (r_jf == '0) ? '0 : r_sum_rd;
        if (r_jf >= {9'd0, i_step}) base = base - {6'd0, r_hist_rd};
        new_sum = base + {6'd0, r_v};
    end

    assign o_job = '{k: r_jk, f: r_jf, slot: r_jslot, sum: new_sum, fin: r_jfin};
    assign o_bk_data = r_bk_data;

    // Memories: front read port, back read port, one write
    always_ff @(posedge i_clk) begin
        r_hist_rd <= hist_mem[{r_slot, k_use}];
        r_sum_rd  <= sum_mem[k_use];
        if (i_bk_rd.en) r_bk_data <= hist_mem[i_bk_rd.addr];
        if (r_state == F_CALC) begin
            hist_mem[{r_jslot, r_jk}] <= r_v;
            sum_mem[r_jk]             <= new_sum;
        end
    end

    // Latch the accepted transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_jk    <= k_use;
            r_jf    <= r_f;
            r_jslot <= r_slot;
            r_v     <= i_texel;
            r_jfin  <= i_fin;
        end
    end

    // Counters; hold input after any final-flagged texel until the back has
    // finished its flush, since the flush reads history the next frame rewrites
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_k     <= '0;
            r_f     <= '0;
            r_slot  <= '0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_drain && i_q_empty && i_back_idle && r_state == F_IDLE) r_drain <= 1'b0;
            if (r_state == F_CALC && r_jfin) r_drain <= 1'b1;
            if (i_cfg_we) begin
                r_k    <= '0;
                r_f    <= '0;
                r_slot <= '0;
            end else if (r_state == F_CALC) begin
                if (wrap) begin
                    r_k <= '0;
                    if (r_jfin) begin
                        r_f     <= '0;
                        r_slot  <= '0;
                    end else begin
                        r_slot <= ({1'b0, r_jslot} + 7'd1 >= i_step) ? '0 : r_jslot + 6'd1;
                        if (r_jf != FrameW'(MaxFrames - 1)) r_f <= r_jf + 16'd1;
                    end
                end else begin
                    r_k <= r_jk + 12'd1;
                end
            end
        end
    end

endmodule

@@ hdl/cwra_queue.sv @@
// Two-entry job queue between the front and back parts.
// Depends on cwra_pkg for the job record.
module cwra_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cwra_pkg::t_job i_job,
    input  logic           i_pop,
    output cwra_pkg::t_job o_head,
    output logic           o_full,
    output logic           o_empty
);
    import cwra_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

@@ hdl/cwra_back.sv @@
// Back part: turns jobs into averaged results, trims flush windows, divides.
// Depends on cwra_pkg; reads the frame history through the front's port.
module cwra_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [cwra_pkg::StepW-1:0]    i_step,
    input  logic                          i_q_empty,
    input  cwra_pkg::t_job                i_head,
    output logic                          o_pop,
    output logic                          o_idle,
    output cwra_pkg::t_hist_rd            o_rd,
    input  logic [cwra_pkg::PixW-1:0]     i_rd_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [cwra_pkg::PixW-1:0]     o_avg,
    output logic [cwra_pkg::FrameW-1:0]   o_frame,
    output logic [cwra_pkg::TexW-1:0]     o_texel,
    output logic                          o_last
);
    import cwra_pkg::*;

    t_back_state r_state, n_state;
    logic [TexW-1:0]   r_k;
    logic [FrameW-1:0] r_f;
    logic [SlotW-1:0]  r_slot;
    logic [SumW-1:0]   r_sum;
    logic              r_fin;
    logic [FrameW-1:0] r_a;
    logic [FrameW-1:0] r_o;
    logic [SumW-1:0]   r_dvd;
    logic [SumW-1:0]   r_quo;
    logic [StepW-1:0]  r_rem;
    logic [StepW-1:0]  r_div;
    logic [3:0]        r_cnt;

    logic [StepW-1:0]  half, lead;
    logic [FrameW-1:0] a0, s, head_o;
    logic              head_emit, need_sub;
    logic [SlotW-1:0]  back_dist, ring_sl;
    logic [StepW:0]    ring_raw;
    logic [PixW:0]     trial;

    assign half = i_step >> 1;
    assign lead = i_step - 7'd1 - half;
    assign a0   = ({1'b0, i_head.f} + 17'd1 >= {10'd0, i_step})
                  ? FrameW'({1'b0, i_head.f} + 17'd1 - {10'd0, i_step}) : '0;
    assign head_emit = i_head.fin || (i_head.f >= {9'd0, lead});
    assign head_o    = (i_head.f >= {9'd0, lead}) ? i_head.f - {9'd0, lead} : '0;

    // Window start for the current output frame, and the ring slot to drop
    assign s         = (r_o >= {9'd0, half}) ? r_o - {9'd0, half} : '0;
    assign need_sub  = (r_a < s);
    assign back_dist = SlotW'(r_f - r_a);
    assign ring_raw  = {2'b0, r_slot} + {1'b0, i_step} - {2'b0, back_dist};
    assign ring_sl   = (ring_raw >= {1'b0, i_step}) ? SlotW'(ring_raw - {1'b0, i_step})
                                                    : SlotW'(ring_raw);
    assign trial     = {r_rem, r_dvd[SumW-1]};

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:  if (!i_q_empty && head_emit) n_state = B_CHECK;
            B_CHECK: n_state = need_sub ? B_WAIT : B_DIV;
            B_WAIT:  n_state = B_CHECK;
            B_DIV:   if (r_cnt == 4'd0) n_state = B_OUT;
            B_OUT:   if (i_ready) n_state = (!r_fin || r_o == r_f) ? B_IDLE : B_CHECK;
            default: n_state = B_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_pop   = (r_state == B_IDLE) && !i_q_empty;
        o_idle  = (r_state == B_IDLE);
        o_rd    = '{en: (r_state == B_CHECK) && need_sub, addr: {ring_sl, r_k}};
        o_valid = (r_state == B_OUT);
        o_avg   = r_quo[PixW-1:0];
        o_frame = r_o;
        o_texel = r_k;
        o_last  = !r_fin || (r_o == r_f);
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_k    <= i_head.k;
                r_f    <= i_head.f;
                r_slot <= i_head.slot;
                r_sum  <= i_head.sum;
                r_fin  <= i_head.fin;
                r_a    <= a0;
                r_o    <= head_o;
            end
            B_CHECK: begin
                r_dvd <= r_sum;
                r_quo <= '0;
                r_rem <= '0;
                r_div <= StepW'(r_f - r_a + 16'd1);
                r_cnt <= 4'(SumW - 1);
            end
            B_WAIT: begin
                r_sum <= r_sum - {6'd0, i_rd_data};
                r_a   <= r_a + 16'd1;
            end
            B_DIV: begin
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt - 4'd1;
                if (trial >= {1'b0, r_div}) begin
                    r_rem <= StepW'(trial - {1'b0, r_div});
                    r_quo <= {r_quo[SumW-2:0], 1'b1};
                end else begin
                    r_rem <= trial[StepW-1:0];
                    r_quo <= {r_quo[SumW-2:0], 1'b0};
                end
            end
            B_OUT: if (i_ready) r_o <= r_o + 16'd1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= B_IDLE;
        else          r_state <= n_state;
    end

endmodule

@@ hdl/centered_window_row_average.sv @@
// Centered moving average over a stream of byte frames: for each texel position
// the output for frame o is the floor mean of frames o-step/2 .. o-step/2+step-1,
// clipped to existing frames. The front does a sum read-modify-write per texel
// and takes the next only after pushing it, while the 2-entry queue has room;
// the back pops a single-result texel, sets up, runs a 14-step divider and
// outputs, and pops the next job only once that result is taken. Each further
// flush result adds setup, divider and output, plus a history read per frame
// it drops. After a texel flagged final, input waits until its results are out.
module centered_window_row_average (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] texel
    input  logic        i_s_axis_tuser,   // [0] final_frame
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // [7:0] avg_value, [23:8] frame_index,
                                          // [35:24] texel_index, [39:36] zero
    output logic        o_m_axis_tlast,   // last_of_run
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    import cwra_pkg::*;

    logic [StepW-1:0] r_step;
    logic [TpfW-1:0]  r_tpf;
    logic [StepW-1:0] step_eff;
    logic [TpfW-1:0]  tpf_eff;

    logic     push, pop, q_full, q_empty, back_idle;
    t_job     job, head;
    t_hist_rd bk_rd;
    logic [PixW-1:0]   bk_data, avg;
    logic [FrameW-1:0] frame;
    logic [TexW-1:0]   texel;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 7'd30;
            r_tpf  <= 13'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegStep: r_step <= i_cfg_data[StepW-1:0];
                RegTpf:  r_tpf  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign step_eff = (r_step == '0) ? 7'd1 : (r_step > 7'(MaxStep)) ? 7'(MaxStep) : r_step;
    assign tpf_eff  = (r_tpf == '0) ? 13'd1 : (r_tpf > 13'(MaxTexels)) ? 13'(MaxTexels) : r_tpf;

    cwra_front u_front (
        .i_clk, .i_rst_n,
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_texel     (i_s_axis_tdata),
        .i_fin       (i_s_axis_tuser),
        .i_cfg_we,
        .i_step      (step_eff),
        .i_tpf       (tpf_eff),
        .i_q_full    (q_full),
        .i_q_empty   (q_empty),
        .i_back_idle (back_idle),
        .o_push      (push),
        .o_job       (job),
        .i_bk_rd     (bk_rd),
        .o_bk_data   (bk_data)
    );

    cwra_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    cwra_back u_back (
        .i_clk, .i_rst_n,
        .i_step    (step_eff),
        .i_q_empty (q_empty),
        .i_head    (head),
        .o_pop     (pop),
        .o_idle    (back_idle),
        .o_rd      (bk_rd),
        .i_rd_data (bk_data),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_avg     (avg),
        .o_frame   (frame),
        .o_texel   (texel),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {4'd0, texel, frame, avg};

endmodule

@@ tb/cwra_checker.sv @@
// Checker for centered_window_row_average: watches the texel, result and
// register ports, predicts every averaged byte and compares it. Uses cwra_pkg.
`timescale 1ns / 100ps

module cwra_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] texel
    input  logic        i_s_axis_tuser,   // [0] final_frame
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [39:0] i_m_axis_tdata,   // [7:0] avg, [23:8] frame, [35:24] texel
    input  logic        i_m_axis_tlast,   // last_of_run
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    import cwra_pkg::*;

    typedef struct packed {
        logic [7:0]  avg;
        logic [15:0] frame;
        logic [11:0] pos;
        logic        last;
    } t_avg_byte;

    t_avg_byte   avg_q[$];
    logic [7:0]  hist_mem [MaxStep*MaxTexels];
    int unsigned win_sum  [MaxTexels];
    int unsigned cur_frame, cur_pos, cur_slot;
    logic [6:0]  step_reg;
    logic [12:0] tpf_reg;

    assign o_pending = avg_q.size();

    task automatic clear_window();
        for (int i = 0; i < MaxTexels; i++) win_sum[i] = 0;
        cur_frame = 0;
        cur_pos   = 0;
        cur_slot  = 0;
    endtask

    task automatic push_avg(int unsigned avg, int unsigned fr, int unsigned pos, bit last);
        t_avg_byte r;
        r.avg   = avg[7:0];
        r.frame = fr[15:0];
        r.pos   = pos[11:0];
        r.last  = last;
        avg_q   = {avg_q, r};
    endtask

    // Predict the averaged bytes that one texel causes
    task automatic predict_texel(logic [7:0] v, logic fin);
        int unsigned step, tpf, k, f, slot, half, lead, addr, sum, a, o, s, sl;
        step = (step_reg < 1) ? 1 : (step_reg > MaxStep) ? MaxStep : step_reg;
        tpf  = (tpf_reg < 1) ? 1 : (tpf_reg > MaxTexels) ? MaxTexels : tpf_reg;
        k    = (cur_pos >= tpf) ? 0 : cur_pos;
        f    = cur_frame;
        slot = cur_slot % step;
        half = step / 2;
        lead = step - 1 - half;
        addr = slot * MaxTexels + k;
        sum  = win_sum[k];
        if (f >= step) sum = sum - hist_mem[addr];
        sum = (sum + v) & 16'h3FFF;
        hist_mem[addr] = v;
        win_sum[k] = sum;
        a = (f + 1 >= step) ? f + 1 - step : 0;
        if (!fin) begin
            if (f >= lead) push_avg(sum / (f - a + 1), f - lead, k, 1'b1);
        end else begin
            // flush: drop frames from the window front as it slides to the end
            for (o = (f >= lead) ? f - lead : 0; o <= f; o++) begin
                s = (o >= half) ? o - half : 0;
                while (a < s) begin
                    sl = (slot + step - (f - a)) % step;
                    sum = sum - hist_mem[sl * MaxTexels + k];
                    a++;
                end
                push_avg(sum / (f - a + 1), o, k, o == f);
            end
        end
        k++;
        if (k >= tpf) begin
            if (fin) clear_window();
            else begin
                cur_pos  = 0;
                cur_slot = (slot + 1) % step;
                if (f < MaxFrames - 1) cur_frame = f + 1;
            end
        end else begin
            cur_pos = k;
        end
    endtask

    task automatic report(string what, t_avg_byte exp_r, t_avg_byte got_r);
        if (o_errors < 10)
            $display("%0t %s: exp avg=%0d frame=%0d pos=%0d last=%0d, %s",
                     $realtime, what, exp_r.avg, exp_r.frame, exp_r.pos, exp_r.last,
                     $sformatf("got avg=%0d frame=%0d pos=%0d last=%0d",
                               got_r.avg, got_r.frame, got_r.pos, got_r.last));
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_avg_byte got_r, exp_r;
        if (!i_rst_n) begin
            o_errors = 0;
            step_reg = 7'd30;
            tpf_reg  = 13'd4096;
            clear_window();
            avg_q.delete();
        end else begin
            // result transaction
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got_r.avg   = i_m_axis_tdata[7:0];
                got_r.frame = i_m_axis_tdata[23:8];
                got_r.pos   = i_m_axis_tdata[35:24];
                got_r.last  = i_m_axis_tlast;
                if (avg_q.size() == 0) begin
                    report("unexpected result", '0, got_r);
                end else begin
                    exp_r = avg_q.pop_front();
                    if (exp_r != got_r || i_m_axis_tdata[39:36] != 4'd0)
                        report("result mismatch", exp_r, got_r);
                end
            end
            // texel transaction
            if (i_s_axis_tvalid && i_s_axis_tready)
                predict_texel(i_s_axis_tdata, i_s_axis_tuser);
            // register write empties the block
            if (i_cfg_we) begin
                if (i_cfg_index == RegStep) step_reg = i_cfg_data[6:0];
                else                        tpf_reg  = i_cfg_data;
                clear_window();
            end
        end
    end

endmodule

@@ tb/testbench.sv @@
// Top of the centered_window_row_average testbench: clock, reset, texel and
// register stimulus, result back-pressure and verdict. Needs cwra_checker.
`timescale 1ns / 100ps

module testbench;
    import cwra_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;
    int          errors, pending;
    int          texels_sent = 0;
    bit          quiet = 0;
    int          out_stall = 0;
    int          idle_cycles = 0;

    localparam int IdleLimit = 4000;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    centered_window_row_average u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    cwra_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    // Result side back-pressure in random bursts
    always @(posedge i_clk) begin
        if (out_stall > 0) begin
            out_stall <= out_stall - 1;
            m_tready  <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            out_stall <= $urandom_range(0, 6);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("centered_window_row_average: mismatch");
            $finish;
        end
    end

    // Send one texel; returns right after the edge that took it
    task automatic send_texel(logic [7:0] v, logic fin);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= fin;
        do @(posedge i_clk); while (!s_tready);
        texels_sent++;
        if (texels_sent >= 80) quiet = 1;
    endtask

    // Let all results drain, then the block's own tail
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [6:0] step, logic [12:0] tpf);
        cfg_we    <= 1'b1;
        cfg_index <= RegStep;
        cfg_data  <= {6'd0, step};
        @(posedge i_clk);
        cfg_index <= RegTpf;
        cfg_data  <= tpf;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Frames; the last is final unless cut, noise flags random texels final
    task automatic send_frames(int nframes, int tpf, bit cut, int noise);
        for (int fr = 0; fr < nframes; fr++)
            for (int t = 0; t < tpf; t++)
                send_texel(8'($urandom_range(0, 255)),
                           (!cut && fr == nframes - 1) ||
                           (noise > 0 && $urandom_range(1, noise) == 1));
    endtask

    initial begin
        int step, tpf, eff_step, eff_tpf, nframes;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one-frame window, field extremes, final on the third one-texel frame
        write_regs(7'd1, 13'd1);
        send_texel(8'd255, 1'b0);
        send_texel(8'd0, 1'b0);
        send_texel(8'd128, 1'b1);
        wait_drained();
        // out-of-range low values act as 1
        write_regs(7'd0, 13'd0);
        send_texel(8'd255, 1'b0);
        send_texel(8'd1, 1'b1);
        wait_drained();
        // step 2, three texels, final on one byte of a middle frame
        write_regs(7'd2, 13'd3);
        send_texel(8'd255, 1'b0); send_texel(8'd255, 1'b0); send_texel(8'd0, 1'b0);
        send_texel(8'd0, 1'b1);   send_texel(8'd255, 1'b0); send_texel(8'd7, 1'b0);
        send_texel(8'd255, 1'b1); send_texel(8'd255, 1'b1); send_texel(8'd255, 1'b1);
        wait_drained();
        // out-of-range high values clamp; final bytes on a partial large frame
        write_regs(7'd127, 13'd8191);
        send_texel(8'd200, 1'b1);
        send_texel(8'd0, 1'b1);
        wait_drained();
        // widest window, early frames give no result, flush gives many
        write_regs(7'd64, 13'd1);
        send_frames(5, 1, 0, 0);
        wait_drained();

        // Random phases
        while (texels_sent < 95) begin
            case ($urandom_range(0, 7))
                0: step = 1;
                1: step = 64;
                2: step = $urandom_range(0, 1) ? 0 : 127;
                default: step = $urandom_range(1, 12);
            endcase
            tpf = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 0 : 8191)
                                              : $urandom_range(1, 5);
            eff_step = (step < 1) ? 1 : (step > 64) ? 64 : step;
            eff_tpf  = (tpf < 1) ? 1 : tpf;
            write_regs(step[6:0], tpf[12:0]);
            if (eff_tpf > 64) begin
                send_frames(1, $urandom_range(1, 4), 0, 1);
            end else begin
                nframes = $urandom_range(1, eff_step + 2);
                if (nframes * eff_tpf > 20) nframes = (20 + eff_tpf - 1) / eff_tpf;
                send_frames(nframes, eff_tpf, $urandom_range(0, 7) == 0,
                            $urandom_range(0, 1) ? 20 : 0);
            end
            wait_drained();
        end

        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("centered_window_row_average: match");
        else
            $display("centered_window_row_average: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
hdl/cwra_pkg.sv
hdl/cwra_front.sv
hdl/cwra_queue.sv
hdl/cwra_back.sv
hdl/centered_window_row_average.sv
tb/cwra_checker.sv
tb/testbench.sv
